/* src/iucc_pkg.sv */
// ----------------------------------------------------------------------------
// iucc_pkg
// Shared constants and types for the interval union covered count block.
// ----------------------------------------------------------------------------
`default_nettype none

package iucc_pkg;

  localparam int unsigned MAX_RANGES_DEF = 128;
  localparam int unsigned VALUE_BITS_DEF = 50;
  // width of the covered count on the result channel
  localparam int unsigned COUNT_W        = 51;

  // control broadcast to every cell of the sorted chain
  typedef struct packed {
    logic ins_en;     // insert the broadcast endpoint this cycle
    logic ins_close;  // broadcast endpoint is a close
    logic shift_en;   // move every entry one place towards the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/iucc_if.sv */
// ----------------------------------------------------------------------------
// iucc_if
// Valid/ready channels of the interval union covered count block.
// ----------------------------------------------------------------------------
`default_nettype none

interface iucc_range_if import iucc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] range_low;
  logic [VALUE_BITS-1:0] range_high;
  logic                  last_range;

  modport source (output valid, range_low, range_high, last_range, input ready);
  modport sink   (input valid, range_low, range_high, last_range, output ready);
endinterface

interface iucc_result_if import iucc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] covered_count;
  logic               table_full_drop;
  logic               bad_range_drop;

  modport source (output valid, covered_count, table_full_drop, bad_range_drop,
                  input ready);
  modport sink   (input valid, covered_count, table_full_drop, bad_range_drop,
                  output ready);
endinterface

`default_nettype wire

/* src/iucc_cell.sv */
// ----------------------------------------------------------------------------
// iucc_cell
// One entry of the sorted endpoint chain: compares against the broadcast
// endpoint, takes it or its left neighbour on insert, its right on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_cell import iucc_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [VALUE_BITS-1:0] ins_value_i,
  input  wire logic                  left_ins_i,
  input  wire logic                  left_valid_i,
  input  wire logic                  left_close_i,
  input  wire logic [VALUE_BITS-1:0] left_value_i,
  input  wire logic                  right_valid_i,
  input  wire logic                  right_close_i,
  input  wire logic [VALUE_BITS-1:0] right_value_i,
  output logic                       ins_o,
  output logic                       valid_o,
  output logic                       close_o,
  output logic [VALUE_BITS-1:0]      value_o
);

  logic                  valid_q, valid_d;
  logic                  close_q, close_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  // new endpoint goes at or before this entry; opens sort ahead of closes
  assign ins_o = !valid_q || (value_q > ins_value_i) ||
                 ((value_q == ins_value_i) && !ctrl_i.ins_close && close_q);

  always_comb begin
    valid_d = valid_q;
    close_d = close_q;
    value_d = value_q;
    if (ctrl_i.shift_en) begin
      valid_d = right_valid_i;
      close_d = right_close_i;
      value_d = right_value_i;
    end else if (ctrl_i.ins_en && ins_o) begin
      if (left_ins_i) begin
        valid_d = left_valid_i;
        close_d = left_close_i;
        value_d = left_value_i;
      end else begin
        valid_d = 1'b1;
        close_d = ctrl_i.ins_close;
        value_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    close_q <= close_d;
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign close_o = close_q;
  assign value_o = value_q;

endmodule

`default_nettype wire

/* src/iucc_sweep.sv */
// ----------------------------------------------------------------------------
// iucc_sweep
// Nesting counter over the endpoints leaving the chain head; sums the
// length of every covered run.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_sweep import iucc_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  close_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  input  wire logic                  clear_i,
  output logic [COUNT_W-1:0]         total_o
);

  localparam int unsigned NEST_W = $clog2(MAX_RANGES + 1);
  localparam int unsigned LEN_W  = VALUE_BITS + 1;

  logic [NEST_W-1:0]     nest_q, nest_d;
  logic [VALUE_BITS-1:0] start_q, start_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  len_v_q, len_v_d;
  logic [COUNT_W-1:0]    total_q, total_d;

  always_comb begin
    nest_d  = nest_q;
    start_d = start_q;
    len_d   = len_q;
    len_v_d = 1'b0;
    total_d = total_q;
    // run length is registered, added to the total in the next cycle
    if (len_v_q) begin
      total_d = total_q + COUNT_W'(len_q);
    end
    if (clear_i) begin
      nest_d  = '0;
      total_d = '0;
    end else if (en_i) begin
      if (!close_i) begin
        if (nest_q == '0) begin
          start_d = value_i;
        end
        nest_d = nest_q + NEST_W'(1);
      end else if (nest_q != '0) begin
        nest_d = nest_q - NEST_W'(1);
        if (nest_q == NEST_W'(1)) begin
          len_d   = LEN_W'(value_i - start_q) + LEN_W'(1);
          len_v_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nest_q  <= '0;
      len_v_q <= 1'b0;
      total_q <= '0;
    end else begin
      nest_q  <= nest_d;
      len_v_q <= len_v_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
  end

  assign total_o = total_q;

endmodule

`default_nettype wire

/* src/interval_union_covered_count.sv */
// ----------------------------------------------------------------------------
// interval_union_covered_count
// Union length of a batch of inclusive ranges via a sorted endpoint chain.
// ----------------------------------------------------------------------------
// A range beat holds off the next: the low end is inserted into the sorted
// chain of 2*MAX_RANGES cells in the cycle it is accepted, the high end in
// the next, one endpoint per cycle being what the chain can place. A beat
// marked last_range is followed by the sweep, which shifts the chain out of
// its head one endpoint a cycle until the head is empty, and the result is
// registered once the output is free. Ranges with low above high, or
// arriving when the chain has no room for two more endpoints, are dropped
// and reported in the result of their batch; the chain and both flags are
// empty again once the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_union_covered_count import iucc_pkg::*; #(
  parameter int unsigned MAX_RANGES = MAX_RANGES_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  iucc_range_if.sink     range_i,
  iucc_result_if.source  result_o
);

  localparam int unsigned DEPTH  = 2 * MAX_RANGES;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HIGH  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  full_q, full_d;
  logic                  bad_q, bad_d;
  logic                  ok_q, ok_d;
  logic                  last_q, last_d;
  logic [VALUE_BITS-1:0] high_q;

  logic                  out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]    out_count_q;
  logic                  out_full_q, out_bad_q;

  logic                  in_acc;
  logic                  lo_gt_hi, no_room, range_ok;
  logic                  out_load, clear;
  cell_ctrl_t            ctrl;
  logic [VALUE_BITS-1:0] ins_value;
  logic [COUNT_W-1:0]    total;

  // chain wiring: cell i drives index i+1, index 0 and DEPTH+1 are padding
  logic                  ins_w   [DEPTH+1];
  logic                  valid_w [DEPTH+2];
  logic                  close_w [DEPTH+2];
  logic [VALUE_BITS-1:0] value_w [DEPTH+2];

  assign range_i.ready = (state_q == ST_IDLE);
  assign in_acc        = range_i.valid && range_i.ready;
  assign lo_gt_hi      = range_i.range_low > range_i.range_high;
  assign no_room       = fill_q > FILL_W'(DEPTH - 2);
  assign range_ok      = !lo_gt_hi && !no_room;

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);
  assign clear    = out_load;

  always_comb begin
    ctrl      = '0;
    ins_value = high_q;
    unique case (state_q)
      ST_IDLE: begin
        ctrl.ins_en = in_acc && range_ok;
        ins_value   = range_i.range_low;
      end
      ST_HIGH: begin
        ctrl.ins_en    = ok_q;
        ctrl.ins_close = 1'b1;
      end
      ST_SWEEP: begin
        ctrl.shift_en = valid_w[1];
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    full_d  = full_q;
    bad_d   = bad_q;
    ok_d    = ok_q;
    last_d  = last_q;
    if (ctrl.ins_en) begin
      fill_d = fill_q + FILL_W'(1);
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ok_d    = range_ok;
          last_d  = range_i.last_range;
          bad_d   = bad_q || lo_gt_hi;
          full_d  = full_q || (!lo_gt_hi && no_room);
          state_d = ST_HIGH;
        end
      end
      ST_HIGH: begin
        state_d = last_q ? ST_SWEEP : ST_IDLE;
      end
      ST_SWEEP: begin
        if (!valid_w[1]) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          fill_d  = '0;
          full_d  = 1'b0;
          bad_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      full_q  <= 1'b0;
      bad_q   <= 1'b0;
      ok_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      full_q  <= full_d;
      bad_q   <= bad_d;
      ok_q    <= ok_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      high_q <= range_i.range_high;
    end
  end

  // sorted endpoint chain
  assign ins_w[0]       = 1'b0;
  assign valid_w[0]     = 1'b0;
  assign close_w[0]     = 1'b0;
  assign value_w[0]     = '0;
  assign valid_w[DEPTH+1] = 1'b0;
  assign close_w[DEPTH+1] = 1'b0;
  assign value_w[DEPTH+1] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    iucc_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .ins_value_i   (ins_value),
      .left_ins_i    (ins_w[i]),
      .left_valid_i  (valid_w[i]),
      .left_close_i  (close_w[i]),
      .left_value_i  (value_w[i]),
      .right_valid_i (valid_w[i+2]),
      .right_close_i (close_w[i+2]),
      .right_value_i (value_w[i+2]),
      .ins_o         (ins_w[i+1]),
      .valid_o       (valid_w[i+1]),
      .close_o       (close_w[i+1]),
      .value_o       (value_w[i+1])
    );
  end

  iucc_sweep #(
    .MAX_RANGES (MAX_RANGES),
    .VALUE_BITS (VALUE_BITS)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ctrl.shift_en),
    .close_i (close_w[1]),
    .value_i (value_w[1]),
    .clear_i (clear),
    .total_o (total)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_count_q <= total;
      out_full_q  <= full_q;
      out_bad_q   <= bad_q;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.covered_count   = out_count_q;
  assign result_o.table_full_drop = out_full_q;
  assign result_o.bad_range_drop  = out_bad_q;

endmodule

`default_nettype wire

/* src/iucc_checker.sv */
// ----------------------------------------------------------------------------
// iucc_checker
// Port-level checks on the interval union covered count block.
// ----------------------------------------------------------------------------
`default_nettype none

module iucc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_last_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // no range beat is accepted directly after another
  a_two_cycle_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("range accepted on consecutive cycles");

  // the last beat is followed by its high insert and then the sweep, both holding off input
  a_sweep_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_last_i) |=> !in_ready_i ##1 !in_ready_i)
    else $error("range taken before the sweep started");

  // a beat that does not close the batch never produces a result
  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_last_i) |=> !$rose(out_valid_i))
    else $error("result raised by a range that is not last");

  // a pending result holds until taken
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result dropped while stalled");

endmodule

bind interval_union_covered_count iucc_checker u_iucc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (range_i.valid),
  .in_ready_i  (range_i.ready),
  .in_last_i   (range_i.last_range),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready)
);

`default_nettype wire
